// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every edge outside reset
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ITOA_ASSERT(lbl, prop, msg)
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/itoa_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function of the formatter.
package itoa_pkg;

  localparam int VALUE_W    = 64;
  localparam int BIN_W      = 32;
  localparam int NIB_W      = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = BCD_DIGITS * NIB_W;
  localparam int DEC_PAD_W  = VALUE_W - BCD_W;
  localparam int HEX_PAD_W  = VALUE_W - BIN_W;
  localparam int BIT_CNT_W  = $clog2(BIN_W);
  localparam int CNT_W      = 5;
  localparam int CHAR_W     = 8;

  localparam logic [CNT_W-1:0] NDIG_DEC   = CNT_W'(BCD_DIGITS);
  localparam logic [CNT_W-1:0] NDIG_HEX32 = CNT_W'(BIN_W / NIB_W);
  localparam logic [CNT_W-1:0] NDIG_PTR   = CNT_W'(VALUE_W / NIB_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30; // '0'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_BASE = 8'h37; // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_LOWER_BASE = 8'h57; // 'a' - 10

  typedef enum logic [1:0] {
    OP_DEC       = 2'd0,
    OP_HEX_LOWER = 2'd1,
    OP_HEX_UPPER = 2'd2,
    OP_PTR       = 2'd3
  } op_t;

  // Load request from the top-level sequencer to the digit emitter
  typedef struct packed {
    logic               valid;
    op_t                mode;
    logic [VALUE_W-1:0] digits;   // digits aligned to the MS end
    logic [CNT_W-1:0]   ndigits;  // digit slots before zero stripping
  } emit_load_t;

  function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] nib,
                                                      input logic upper);
    logic [CHAR_W-1:0] base;
    if (nib < 4'd10) begin
      base = CHAR_ZERO;
    end else if (upper) begin
      base = CHAR_UPPER_BASE;
    end else begin
      base = CHAR_LOWER_BASE;
    end
    return base + CHAR_W'(nib);
  endfunction

endpackage

// ===== hdl/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter.
// Takes one number and a format code per item and sends its ASCII digits, most
// significant first with leading zeros dropped, one character per result item.
// A hex item is accepted, its leading zero digits are skipped, its characters
// are sent, and the sequencer then returns to idle. A decimal item first runs
// the bit-serial BCD converter, one bit of the value per cycle, then is loaded
// into the emitter and goes on as a hex item does. The output register lets
// the next item be accepted while the last character still waits to be taken;
// a stalled output adds its stall cycles to the emitting phase.
module integer_to_ascii_formatter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [itoa_pkg::VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]  ascii_char,
  output logic                         last,
  output logic [itoa_pkg::CNT_W-1:0]   digit_count
);
  import itoa_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } top_state_t;

  top_state_t       state;
  op_t              op_in;
  logic             in_fire;
  logic             bcd_start;
  logic             bcd_busy;
  logic             bcd_done;
  logic [BCD_W-1:0] bcd_digits;
  logic             emit_busy;
  emit_load_t       load;

  assign op_in     = op_t'(op);
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign bcd_start = in_fire && (op_in == OP_DEC);

  // Emitter load: hex straight from the input, decimal once BCD is ready
  always_comb begin
    load = '0;
    if (state == ST_CONV) begin
      load.valid   = bcd_done;
      load.mode    = OP_DEC;
      load.digits  = {bcd_digits, {DEC_PAD_W{1'b0}}};
      load.ndigits = NDIG_DEC;
    end else begin
      load.valid = in_fire && (op_in != OP_DEC);
      load.mode  = op_in;
      if (op_in == OP_PTR) begin
        load.digits  = value;
        load.ndigits = NDIG_PTR;
      end else begin
        load.digits  = {value[BIN_W-1:0], {HEX_PAD_W{1'b0}}};
        load.ndigits = NDIG_HEX32;
      end
    end
  end

  // Item sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (bcd_start) begin
            state <= ST_CONV;
          end else if (in_fire) begin
            state <= ST_EMIT;
          end
        end
        ST_CONV: begin
          if (bcd_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!emit_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  itoa_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .bin_in (value[BIN_W-1:0]),
    .busy   (bcd_busy),
    .done   (bcd_done),
    .bcd    (bcd_digits)
  );

  itoa_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .busy        (emit_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ascii_char  (ascii_char),
    .last        (last),
    .digit_count (digit_count)
  );

  `ITOA_ASSERT(a_conv_emit_idle, state == ST_CONV |-> !emit_busy, "emitter busy during conversion")
  `ITOA_ASSERT(a_conv_running, state == ST_CONV |-> bcd_busy || bcd_done, "conversion stalled")
  `ITOA_ASSERT(a_idle_no_work, state == ST_IDLE |-> !emit_busy && !bcd_busy, "idle with work left")

endmodule

// ===== hdl/itoa_bcd.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module itoa_bcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [itoa_pkg::BIN_W-1:0] bin_in,
  output logic                       busy,
  output logic                       done,
  output logic [itoa_pkg::BCD_W-1:0] bcd
);
  import itoa_pkg::*;

  logic [BIN_W-1:0]     bin_sr;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [BCD_W-1:0]     bcd_adj;

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (bcd[d*NIB_W +: NIB_W] >= 4'd5) begin
        bcd_adj[d*NIB_W +: NIB_W] = bcd[d*NIB_W +: NIB_W] + 4'd3;
      end else begin
        bcd_adj[d*NIB_W +: NIB_W] = bcd[d*NIB_W +: NIB_W];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_CNT_W'(BIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: binary bits leave MS first into the BCD register
  always_ff @(posedge clk) begin
    if (start) begin
      bin_sr <= bin_in;
      bcd    <= '0;
    end else if (busy) begin
      bin_sr <= {bin_sr[BIN_W-2:0], 1'b0};
      bcd    <= {bcd_adj[BCD_W-2:0], bin_sr[BIN_W-1]};
    end
  end

endmodule

// ===== hdl/itoa_emit.sv =====
// Digit emitter: strips leading zeros, sends one char per cycle unless stalled.
module itoa_emit (
  input  logic                             clk,
  input  logic                             rst,
  input  itoa_pkg::emit_load_t             load,
  output logic                             busy,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]      ascii_char,
  output logic                             last,
  output logic [itoa_pkg::CNT_W-1:0]       digit_count
);
  import itoa_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_SKIP = 3'b010,
    E_EMIT = 3'b100
  } emit_state_t;

  emit_state_t        state;
  logic [VALUE_W-1:0] digit_shift;
  logic [CNT_W-1:0]   digits_left;
  op_t                format_mode;
  logic [CNT_W-1:0]   count;
  logic [NIB_W-1:0]   top_nib;
  logic               slot_free;
  logic               fire;

  assign top_nib   = digit_shift[VALUE_W-1 -: NIB_W];
  assign slot_free = !out_valid || out_ready;
  assign fire      = (state == E_EMIT) && slot_free;
  assign busy      = (state != E_IDLE);

  // Sequencer and digit shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= E_IDLE;
      digit_shift <= '0;
      digits_left <= '0;
      format_mode <= OP_DEC;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (load.valid) begin
            digit_shift <= load.digits;
            digits_left <= load.ndigits;
            format_mode <= load.mode;
            state       <= E_SKIP;
          end
        end
        E_SKIP: begin
          if (top_nib == '0 && digits_left > CNT_W'(1)) begin
            digit_shift <= {digit_shift[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
            digits_left <= digits_left - 1'b1;
          end else begin
            state <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (slot_free) begin
            digit_shift <= {digit_shift[VALUE_W-NIB_W-1:0], {NIB_W{1'b0}}};
            digits_left <= digits_left - 1'b1;
            if (digits_left == CNT_W'(1)) begin
              state <= E_IDLE;
            end
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

  // Digit total, fixed once zero stripping ends
  always_ff @(posedge clk) begin
    if (state == E_SKIP) begin
      count <= digits_left;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ascii_char  <= nib_to_ascii(top_nib, format_mode == OP_HEX_UPPER);
      last        <= (digits_left == CNT_W'(1));
      digit_count <= count;
    end
  end

  `ITOA_ASSERT(a_load_when_idle, load.valid |-> state == E_IDLE, "load while emitter busy")
  `ITOA_ASSERT(a_emit_has_digits, state == E_EMIT |-> digits_left != '0, "emit with no digits")
  `ITOA_ASSERT(a_left_range, digits_left <= NDIG_PTR, "digit counter out of range")

endmodule

// ===== verif/tb_integer_to_ascii_formatter_unit.sv =====
// Self-checking testbench for the integer to ASCII formatter: directed table plus random numbers.
module tb_integer_to_ascii_formatter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import itoa_pkg::*;

  localparam int RANDOM_ITEMS = 206;
  localparam int DIR_ROWS     = 24;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 160;
  localparam int HOLD_AT_ITEM = 60;
  localparam int CALM_FROM    = 110;
  localparam int CALM_TO      = 160;
  localparam int IDLE_PCT     = 26;
  localparam int SHOW_MAX     = 10;

  localparam logic [7:0] ASC_ZERO    = "0";
  localparam logic [7:0] ASC_UPPER_A = "A";
  localparam logic [7:0] ASC_LOWER_A = "a";

  // one character as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic [4:0] cnt;
  } char_exp_t;

  // directed row; a non-zero text_len means the digits are typed in below
  typedef struct packed {
    op_t         fmt;
    logic [63:0] num;
    logic [4:0]  text_len;
    logic [127:0] text;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  ascii_char;
  logic        last;
  logic [4:0]  digit_count;

  // typed expectation travelling with the item on offer
  logic [4:0]   cur_len = '0;
  logic [127:0] cur_text = '0;

  char_exp_t digits_due[$];
  stim_row_t directed_rows [DIR_ROWS];

  int items_in    = 0;
  int chars_out   = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  int per_fmt [4] = '{0, 0, 0, 0};
  int longest_hold = 0;
  bit hold_done   = 1'b0;

  integer_to_ascii_formatter_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ascii_char  (ascii_char),
    .last        (last),
    .digit_count (digit_count)
  );

  always #1 clk = ~clk;

  // expected characters of one number, most significant first
  function automatic void predict_digits(op_t fmt, logic [63:0] num);
    logic [63:0] word;
    logic [31:0] rest;
    logic [7:0]  digs [16];
    logic [3:0]  nib;
    int n;
    int top;
    word = (fmt == OP_PTR) ? num : {32'd0, num[31:0]};
    n = 0;
    if (fmt == OP_DEC) begin
      rest = word[31:0];
      digs[0] = ASC_ZERO + 8'(rest % 32'd10);
      rest = rest / 32'd10;
      n = 1;
      while (rest != 0) begin
        digs[n] = ASC_ZERO + 8'(rest % 32'd10);
        rest = rest / 32'd10;
        n++;
      end
    end else begin
      top = 0;
      for (int k = 0; k < 16; k++) begin
        if (word[4*k +: 4] != 4'd0) top = k;
      end
      n = top + 1;
      for (int k = 0; k < n; k++) begin
        nib = word[4*k +: 4];
        if (nib < 4'd10) digs[k] = ASC_ZERO + 8'(nib);
        else if (fmt == OP_HEX_UPPER) digs[k] = ASC_UPPER_A + 8'(nib) - 8'd10;
        else digs[k] = ASC_LOWER_A + 8'(nib) - 8'd10;
      end
    end
    // digits were gathered least significant first
    for (int k = n - 1; k >= 0; k--) begin
      digits_due.push_back('{ch: digs[k], fin: (k == 0), cnt: 5'(n)});
    end
  endfunction

  // random value with a bias towards leading zeros and decimal boundaries
  function automatic logic [63:0] pick_value();
    logic [63:0] r;
    logic [31:0] p;
    int kind;
    r = {$urandom, $urandom};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        return r;
      end
      4, 5: begin
        return r >> $urandom_range(0, 63);
      end
      6: begin
        return {r[63:32], 32'($urandom_range(0, 20))};
      end
      7: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 32'd10;
        return {r[63:32], p - 32'($urandom_range(0, 1))};
      end
      default: begin
        return r >> (4 * $urandom_range(0, 15));
      end
    endcase
  endfunction

  // offer one item; returns at the falling edge after it is taken
  task automatic offer_number(op_t fmt, logic [63:0] num, logic [4:0] len, logic [127:0] text);
    bit calm;
    calm = (items_in >= CALM_FROM) && (items_in < CALM_TO);
    while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= fmt;
    value    <= num;
    cur_len  <= len;
    cur_text <= text;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off, a calm stretch
  always @(negedge clk) begin : sink_proc
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!hold_done && items_in >= HOLD_AT_ITEM) begin
      out_ready <= 1'b0;
      longest_hold = longest_hold + 1;
      if (longest_hold >= HOLD_CYCLES) hold_done = 1'b1;
    end else if (items_in >= CALM_FROM && items_in < CALM_TO) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // scoreboard and watchdog, sampled at the rising edge
  always @(posedge clk) begin : check_proc
    char_exp_t want;
    bit moved;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        moved = 1'b1;
        items_in++;
        per_fmt[op]++;
        if (cur_len != 0) begin
          for (int k = 0; k < cur_len; k++) begin
            digits_due.push_back('{ch: cur_text[8*(cur_len-1-k) +: 8],
                                   fin: (k == cur_len - 1), cnt: cur_len});
          end
        end else begin
          predict_digits(op_t'(op), value);
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        chars_out++;
        if (digits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("[%0t] unexpected character 0x%02h last=%0b count=%0d",
                     $realtime, ascii_char, last, digit_count);
        end else begin
          want = digits_due.pop_front();
          if (ascii_char !== want.ch || last !== want.fin || digit_count !== want.cnt) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display("[%0t] mismatch: want char 0x%02h last=%0b count=%0d, got 0x%02h %0b %0d",
                       $realtime, want.ch, want.fin, want.cnt, ascii_char, last, digit_count);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d characters outstanding",
                 IDLE_LIMIT, digits_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : main_proc
    directed_rows = '{
      // zero in every format
      '{OP_DEC,       64'd0, 5'd1, "0"},
      '{OP_HEX_LOWER, 64'd0, 5'd1, "0"},
      '{OP_HEX_UPPER, 64'd0, 5'd1, "0"},
      '{OP_PTR,       64'd0, 5'd1, "0"},
      // largest values
      '{OP_DEC,       64'h0000_0000_FFFF_FFFF, 5'd10, "4294967295"},
      '{OP_HEX_LOWER, 64'h0000_0000_FFFF_FFFF, 5'd8,  "ffffffff"},
      '{OP_HEX_UPPER, 64'h0000_0000_FFFF_FFFF, 5'd8,  "FFFFFFFF"},
      '{OP_PTR,       64'hFFFF_FFFF_FFFF_FFFF, 5'd16, "ffffffffffffffff"},
      // upper word must be ignored outside pointer format
      '{OP_DEC,       64'hFFFF_FFFF_0000_0000, 5'd1, "0"},
      '{OP_HEX_LOWER, 64'hABCD_0000_0000_0000, 5'd1, "0"},
      '{OP_HEX_UPPER, 64'h1234_5678_0000_ABCD, 5'd4, "ABCD"},
      '{OP_DEC,       64'hFFFF_FFFF_FFFF_FFFF, 5'd10, "4294967295"},
      // pointer format top and bottom bits
      '{OP_PTR,       64'h8000_0000_0000_0000, 5'd16, "8000000000000000"},
      '{OP_PTR,       64'd1,                   5'd1,  "1"},
      '{OP_PTR,       64'h0123_4567_89AB_CDEF, 5'd15, "123456789abcdef"},
      // every letter digit in both cases
      '{OP_HEX_LOWER, 64'h0000_0000_89AB_CDEF, 5'd8, "89abcdef"},
      '{OP_HEX_UPPER, 64'h0000_0000_89AB_CDEF, 5'd8, "89ABCDEF"},
      // decimal carries and the rest through the predictor
      '{OP_DEC,       64'd10,         5'd2, "10"},
      '{OP_DEC,       64'd9,          5'd0, '0},
      '{OP_DEC,       64'd1000000000, 5'd0, '0},
      '{OP_DEC,       64'd999999999,  5'd0, '0},
      '{OP_HEX_LOWER, 64'h10,         5'd0, '0},
      '{OP_HEX_UPPER, 64'hF000_0000,  5'd0, '0},
      '{OP_PTR,       64'h1_0000_0000, 5'd0, '0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_number(directed_rows[i].fmt, directed_rows[i].num,
                   directed_rows[i].text_len, directed_rows[i].text);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      offer_number(op_t'($urandom_range(0, 3)), pick_value(), 5'd0, '0);
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray character
    while (digits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digits_due.size() != 0) mismatches++;
    $display("Formatted %0d numbers: %0d decimal, %0d lower hex, %0d upper hex, %0d pointer.",
             items_in, per_fmt[0], per_fmt[1], per_fmt[2], per_fmt[3]);
    $display("Checked %0d characters, including a %0d-cycle output hold; %0d mismatches.",
             chars_out, longest_hold, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
